// ----- design/obmrs_pkg.sv -----
// Package for the one-wire bridge memory read sequencer.
// Holds the phase type, the bridge command bytes, the queue descriptor and
// the result beat. No dependencies.
package obmrs_pkg;

  // Fixed field widths
  localparam int BYTE_W     = 8;
  localparam int INDEX_W    = 6;
  localparam int LENGTH_W   = 7;
  localparam int CFG_DATA_W = 7;
  localparam int CFG_IDX_W  = 1;

  // Size of the read image; the read stops at min(data_length, IMAGE_BYTES), after at least one byte
  localparam int              IMAGE_BYTES   = 64;
  localparam logic [8:0]      IMAGE_BYTES_L = 9'(IMAGE_BYTES);

  // Depth of the queue between front and back (power of two)
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DATA_LENGTH   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_AGEING_OFFSET = 1'b1;

  localparam logic [LENGTH_W-1:0] DATA_LENGTH_RST   = 7'd64;
  localparam logic [INDEX_W-1:0]  AGEING_OFFSET_RST = 6'd0;

  // Bridge command and check bytes
  localparam logic [BYTE_W-1:0] CMD_RESET_PULSE = 8'hC1;
  localparam logic [BYTE_W-1:0] RESET_ANS_MASK  = 8'hDF;
  localparam logic [BYTE_W-1:0] RESET_ANS_OK    = 8'hCD;
  localparam logic [BYTE_W-1:0] CMD_DATA_MODE   = 8'hE1;
  localparam logic [BYTE_W-1:0] CMD_SKIP_ROM    = 8'hCC;
  localparam logic [BYTE_W-1:0] CMD_READ_MEMORY = 8'hF0;
  localparam logic [BYTE_W-1:0] ADDR_BYTE       = 8'h00;
  localparam logic [BYTE_W-1:0] CMD_READ_SLOT   = 8'hFF;
  localparam logic [BYTE_W-1:0] CMD_COMMAND_END = 8'hE3;

  typedef enum logic [2:0] {
    PH_RESET      = 3'd0,
    PH_WAIT_RESET = 3'd1,
    PH_DATA_MODE  = 3'd2,
    PH_WAIT_SKIP  = 3'd3,
    PH_ADDR_LO    = 3'd4,
    PH_ADDR_HI    = 3'd5,
    PH_START_READ = 3'd6,
    PH_READ       = 3'd7
  } phase_t;

  // One queued job: the first beat, plus a flag for the trailing end beat
  typedef struct packed {
    logic [BYTE_W-1:0]  tx_byte;
    logic               store_valid;
    logic [INDEX_W-1:0] store_index;
    logic [BYTE_W-1:0]  store_data;
    logic               copy_valid;
    logic [INDEX_W-1:0] copy_index;
    logic               final_byte;
  } desc_t;

  // One result beat as shown on the output channel
  typedef struct packed {
    logic [BYTE_W-1:0]  tx_byte;
    logic               store_valid;
    logic [INDEX_W-1:0] store_index;
    logic [BYTE_W-1:0]  store_data;
    logic               copy_valid;
    logic [INDEX_W-1:0] copy_index;
    logic               read_done;
    logic               last;
  } beat_t;

endpackage

// ----- design/obmrs_front.sv -----
// Front end: configuration registers, phase sequencer and answer latch.
// Turns each accepted tick into a queue descriptor, but for a failed answer check. Depends on obmrs_pkg.
module obmrs_front
  import obmrs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_mode,
  input  logic [BYTE_W-1:0]     in_answer_byte,
  input  logic                  q_ready,
  output logic                  push,
  output desc_t                 push_desc
);

  phase_t              phase_r, phase_nxt;
  logic                answer_seen_r, answer_seen_nxt;
  logic [BYTE_W-1:0]   last_answer_r, last_answer_nxt;
  logic [LENGTH_W-1:0] read_pos_r, read_pos_nxt;
  logic [INDEX_W-1:0]  copy_pos_r, copy_pos_nxt;
  logic                first_pass_r, first_pass_nxt;
  logic [LENGTH_W-1:0] data_length_r;
  logic [INDEX_W-1:0]  ageing_offset_r;
  logic                accept;
  logic [8:0]          limit;
  logic [8:0]          pos_inc;

  assign in_ready = q_ready;
  assign accept   = in_valid && in_ready;

  // Clamp the length to the image size
  assign limit   = (9'(data_length_r) > IMAGE_BYTES_L) ? IMAGE_BYTES_L : 9'(data_length_r);
  assign pos_inc = 9'(read_pos_r) + 9'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_RESET;
    end else begin
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      answer_seen_r   <= 1'b0;
      last_answer_r   <= '0;
      read_pos_r      <= '0;
      copy_pos_r      <= '0;
      first_pass_r    <= 1'b1;
      data_length_r   <= DATA_LENGTH_RST;
      ageing_offset_r <= AGEING_OFFSET_RST;
    end else begin
      answer_seen_r <= answer_seen_nxt;
      last_answer_r <= last_answer_nxt;
      read_pos_r    <= read_pos_nxt;
      copy_pos_r    <= copy_pos_nxt;
      first_pass_r  <= first_pass_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_DATA_LENGTH:   data_length_r   <= cfg_wdata;
          CFG_AGEING_OFFSET: ageing_offset_r <= cfg_wdata[INDEX_W-1:0];
        endcase
      end
    end
  end

  always_comb begin
    phase_nxt       = phase_r;
    answer_seen_nxt = answer_seen_r;
    last_answer_nxt = last_answer_r;
    read_pos_nxt    = read_pos_r;
    copy_pos_nxt    = copy_pos_r;
    first_pass_nxt  = first_pass_r;
    push            = 1'b0;
    push_desc       = '0;
    if (accept) begin
      if (in_mode) begin
        // Latch the bridge answer; no result
        last_answer_nxt = in_answer_byte;
        answer_seen_nxt = 1'b1;
      end else begin
        unique case (phase_r)
          PH_RESET: begin
            answer_seen_nxt   = 1'b0;
            phase_nxt         = PH_WAIT_RESET;
            push              = 1'b1;
            push_desc.tx_byte = CMD_RESET_PULSE;
          end
          PH_WAIT_RESET: begin
            if (answer_seen_r && ((last_answer_r & RESET_ANS_MASK) == RESET_ANS_OK)) begin
              phase_nxt         = PH_DATA_MODE;
              push              = 1'b1;
              push_desc.tx_byte = CMD_DATA_MODE;
            end else begin
              phase_nxt = PH_RESET;
            end
          end
          PH_DATA_MODE: begin
            answer_seen_nxt   = 1'b0;
            phase_nxt         = PH_WAIT_SKIP;
            push              = 1'b1;
            push_desc.tx_byte = CMD_SKIP_ROM;
          end
          PH_WAIT_SKIP: begin
            if (answer_seen_r && (last_answer_r == CMD_SKIP_ROM)) begin
              phase_nxt         = PH_ADDR_LO;
              push              = 1'b1;
              push_desc.tx_byte = CMD_READ_MEMORY;
            end else begin
              phase_nxt = PH_RESET;
            end
          end
          PH_ADDR_LO: begin
            phase_nxt         = PH_ADDR_HI;
            push              = 1'b1;
            push_desc.tx_byte = ADDR_BYTE;
          end
          PH_ADDR_HI: begin
            phase_nxt         = PH_START_READ;
            push              = 1'b1;
            push_desc.tx_byte = ADDR_BYTE;
          end
          PH_START_READ: begin
            phase_nxt         = PH_READ;
            read_pos_nxt      = '0;
            copy_pos_nxt      = '0;
            push              = 1'b1;
            push_desc.tx_byte = CMD_READ_SLOT;
          end
          PH_READ: begin
            push                  = 1'b1;
            push_desc.tx_byte     = CMD_READ_SLOT;
            push_desc.store_valid = 1'b1;
            push_desc.store_index = read_pos_r[INDEX_W-1:0];
            push_desc.store_data  = last_answer_r;
            if (first_pass_r && (read_pos_r >= LENGTH_W'(ageing_offset_r))) begin
              push_desc.copy_valid = 1'b1;
              push_desc.copy_index = copy_pos_r;
              copy_pos_nxt         = copy_pos_r + INDEX_W'(1);
            end
            read_pos_nxt = pos_inc[LENGTH_W-1:0];
            if (pos_inc >= limit) begin
              push_desc.final_byte = 1'b1;
              phase_nxt            = PH_RESET;
              first_pass_nxt       = 1'b0;
            end
          end
        endcase
      end
    end
  end

endmodule

// ----- design/obmrs_queue.sv -----
// Short descriptor queue between front and back, held in flip-flops.
// Depends on obmrs_pkg.
module obmrs_queue
  import obmrs_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  desc_t push_desc,
  output logic  q_ready,
  input  logic  pop,
  output logic  q_valid,
  output desc_t q_desc
);

  desc_t             mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r;

  assign q_ready = (count_r != QCNT_W'(QUEUE_DEPTH));
  assign q_valid = (count_r != '0);
  assign q_desc  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + QCNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - QCNT_W'(1);
      end
    end
  end

endmodule

// ----- design/obmrs_back.sv -----
// Back end: expands queue descriptors into result beats through an output
// register; a final read byte adds the end-command beat. Depends on obmrs_pkg.
module obmrs_back
  import obmrs_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  q_valid,
  input  desc_t q_desc,
  output logic  pop,
  output logic  out_valid,
  input  logic  out_ready,
  output beat_t out_beat
);

  logic  out_valid_r, out_valid_nxt;
  beat_t beat_r, beat_nxt;
  logic  pending_r, pending_nxt;
  logic  load;

  assign load      = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_beat  = beat_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    beat_nxt      = beat_r;
    pending_nxt   = pending_r;
    pop           = 1'b0;
    if (load) begin
      priority if (pending_r) begin
        // Trailing end beat of a completed read
        beat_nxt           = '0;
        beat_nxt.tx_byte   = CMD_COMMAND_END;
        beat_nxt.read_done = 1'b1;
        beat_nxt.last      = 1'b1;
        out_valid_nxt      = 1'b1;
        pending_nxt        = 1'b0;
      end else if (q_valid) begin
        pop                  = 1'b1;
        beat_nxt.tx_byte     = q_desc.tx_byte;
        beat_nxt.store_valid = q_desc.store_valid;
        beat_nxt.store_index = q_desc.store_index;
        beat_nxt.store_data  = q_desc.store_data;
        beat_nxt.copy_valid  = q_desc.copy_valid;
        beat_nxt.copy_index  = q_desc.copy_index;
        beat_nxt.read_done   = 1'b0;
        beat_nxt.last        = !q_desc.final_byte;
        out_valid_nxt        = 1'b1;
        pending_nxt          = q_desc.final_byte;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    beat_r <= beat_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pending_r   <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      pending_r   <= pending_nxt;
    end
  end

  // An end beat is owed only while its read byte is on display
  a_pending_shown: assert property (@(posedge clk) disable iff (!rst_n)
    pending_r |-> (out_valid_r && beat_r.store_valid && !beat_r.last))
    else $error("end beat pending without its read byte");

  // The done flag travels only on the final end-command beat
  a_done_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && beat_r.read_done) |->
      (beat_r.last && (beat_r.tx_byte == CMD_COMMAND_END) && !beat_r.store_valid))
    else $error("read_done on a wrong beat");

  // A copy is always part of a store of a read slot
  a_copy_store: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && beat_r.copy_valid) |->
      (beat_r.store_valid && (beat_r.tx_byte == CMD_READ_SLOT)))
    else $error("copy without store");

  // After a read byte that is not last, the end beat follows on the next transfer
  a_end_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_ready && beat_r.store_valid && !beat_r.last) |=>
      (out_valid_r && beat_r.read_done))
    else $error("end beat did not follow the final read byte");

endmodule

// ----- design/onewire_bridge_memory_read_sequencer.sv -----
// Top level of the one-wire bridge memory read sequencer.
// Wires front end, descriptor queue and back end; depends on obmrs_pkg,
// obmrs_front, obmrs_queue and obmrs_back.
//
//   channel  direction  handshake            payload
//   in_      input      in_valid/in_ready    in_mode, in_answer_byte
//   out_     output     out_valid/out_ready  out_tx_byte .. out_last
//   cfg_     input      cfg_we (no wait)     cfg_index, cfg_wdata
//
// The front takes one item per cycle while the two-entry queue has room;
// answer bytes and failed checks leave nothing in the queue.
// The back shows one result per cycle from its output register while out_ready is high;
// the final read byte of a pass yields two results (read slot, then end command).
// Sustained rate: one tick per cycle while out_ready stays high; the final read byte adds a result.
// Reset is synchronous, active low; it restores the reset-pulse phase, the
// register reset values and empties queue and output register.
// A stalled output fills the queue, then drops in_ready; answers are held too.
module onewire_bridge_memory_read_sequencer
  import obmrs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  // input items
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_mode,
  input  logic [BYTE_W-1:0]     in_answer_byte,
  // result items
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [BYTE_W-1:0]     out_tx_byte,
  output logic                  out_store_valid,
  output logic [INDEX_W-1:0]    out_store_index,
  output logic [BYTE_W-1:0]     out_store_data,
  output logic                  out_copy_valid,
  output logic [INDEX_W-1:0]    out_copy_index,
  output logic                  out_read_done,
  output logic                  out_last
);

  // Front to queue
  logic  push;
  desc_t push_desc;
  logic  q_ready;
  // Queue to back
  logic  q_valid;
  desc_t q_desc;
  logic  pop;
  beat_t out_beat;

  // Classify items and advance the phase sequence
  obmrs_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_mode        (in_mode),
    .in_answer_byte (in_answer_byte),
    .q_ready        (q_ready),
    .push           (push),
    .push_desc      (push_desc)
  );

  // Decouple the two sides so each can stall on its own
  obmrs_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_desc (push_desc),
    .q_ready   (q_ready),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_desc    (q_desc)
  );

  // Expand descriptors into result transfers
  obmrs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_desc    (q_desc),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_beat  (out_beat)
  );

  // Break the registered beat out onto the result ports
  assign out_tx_byte     = out_beat.tx_byte;
  assign out_store_valid = out_beat.store_valid;
  assign out_store_index = out_beat.store_index;
  assign out_store_data  = out_beat.store_data;
  assign out_copy_valid  = out_beat.copy_valid;
  assign out_copy_index  = out_beat.copy_index;
  assign out_read_done   = out_beat.read_done;
  assign out_last        = out_beat.last;

endmodule

// ----- tb/sv/tb_top.sv -----
// Self-checking bench for the one-wire bridge memory read sequencer.
// Drives ticks and bridge answers, predicts every result beat in-line and
// scoreboards the output channel; depends on obmrs_pkg and the top module.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import obmrs_pkg::*;

  // Item kinds on the input channel
  localparam logic MODE_TICK   = 1'b0;
  localparam logic MODE_ANSWER = 1'b1;

  localparam int NUM_PHASES    = 12;
  localparam int PHASE_ITEMS   = 128;
  // Front, queue and output register: lets anything still in flight drain
  localparam int SETTLE_CYCLES = 12;
  // Longest quiet stretch is a long sender gap or sink stall or a settle
  localparam int QUIET_LIMIT   = 2000;
  localparam int MAX_PRINTS    = 40;

  // How a directed row is checked
  typedef enum logic [1:0] {
    CHK_MODEL,   // expectation comes from the predictor
    CHK_SILENT,  // no result may appear
    CHK_TYPED    // one command beat, byte typed in the row
  } row_chk_t;

  typedef struct packed {
    logic              mode;
    logic [BYTE_W-1:0] answer;
    row_chk_t          chk;
    logic [BYTE_W-1:0] typed_tx;
  } row_t;

  // Runs with the reset values (length 64, offset 0), so the first pass
  // copies the whole image. Covers a bad reset answer, a missing answer,
  // a masked-bit reset answer, a wrong skip echo, a later answer replacing
  // an earlier one, noise during the address bytes, and the first reads.
  localparam int NUM_ROWS = 25;
  localparam row_t DIR_ROWS [NUM_ROWS] = '{
    '{MODE_TICK,   8'h00,           CHK_TYPED,  CMD_RESET_PULSE},
    '{MODE_ANSWER, 8'h00,           CHK_SILENT, ADDR_BYTE},
    '{MODE_TICK,   8'h00,           CHK_SILENT, ADDR_BYTE},
    '{MODE_TICK,   8'h00,           CHK_TYPED,  CMD_RESET_PULSE},
    '{MODE_TICK,   8'h00,           CHK_SILENT, ADDR_BYTE},
    '{MODE_TICK,   8'h00,           CHK_TYPED,  CMD_RESET_PULSE},
    '{MODE_ANSWER, 8'hED,           CHK_SILENT, ADDR_BYTE},  // bit 5 masked off
    '{MODE_TICK,   8'h00,           CHK_TYPED,  CMD_DATA_MODE},
    '{MODE_TICK,   8'h00,           CHK_TYPED,  CMD_SKIP_ROM},
    '{MODE_ANSWER, RESET_ANS_OK,    CHK_SILENT, ADDR_BYTE},  // wrong echo
    '{MODE_TICK,   8'h00,           CHK_SILENT, ADDR_BYTE},
    '{MODE_TICK,   8'h00,           CHK_TYPED,  CMD_RESET_PULSE},
    '{MODE_ANSWER, 8'h32,           CHK_SILENT, ADDR_BYTE},
    '{MODE_ANSWER, RESET_ANS_OK,    CHK_SILENT, ADDR_BYTE},
    '{MODE_TICK,   8'h00,           CHK_TYPED,  CMD_DATA_MODE},
    '{MODE_TICK,   8'h00,           CHK_TYPED,  CMD_SKIP_ROM},
    '{MODE_ANSWER, CMD_SKIP_ROM,    CHK_SILENT, ADDR_BYTE},
    '{MODE_TICK,   8'h00,           CHK_TYPED,  CMD_READ_MEMORY},
    '{MODE_ANSWER, 8'hFF,           CHK_SILENT, ADDR_BYTE},
    '{MODE_TICK,   8'hFF,           CHK_TYPED,  ADDR_BYTE},
    '{MODE_TICK,   8'h00,           CHK_TYPED,  ADDR_BYTE},
    '{MODE_TICK,   8'h00,           CHK_TYPED,  CMD_READ_SLOT},
    '{MODE_ANSWER, 8'hA5,           CHK_SILENT, ADDR_BYTE},
    '{MODE_TICK,   8'h00,           CHK_MODEL,  ADDR_BYTE},
    '{MODE_TICK,   8'h00,           CHK_MODEL,  ADDR_BYTE}   // no fresh answer
  };

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_valid;
  logic                  in_ready;
  logic                  in_mode;
  logic [BYTE_W-1:0]     in_answer_byte;
  logic                  out_valid;
  logic                  out_ready;
  logic [BYTE_W-1:0]     out_tx_byte;
  logic                  out_store_valid;
  logic [INDEX_W-1:0]    out_store_index;
  logic [BYTE_W-1:0]     out_store_data;
  logic                  out_copy_valid;
  logic [INDEX_W-1:0]    out_copy_index;
  logic                  out_read_done;
  logic                  out_last;

  onewire_bridge_memory_read_sequencer i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_mode         (in_mode),
    .in_answer_byte  (in_answer_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_tx_byte     (out_tx_byte),
    .out_store_valid (out_store_valid),
    .out_store_index (out_store_index),
    .out_store_data  (out_store_data),
    .out_copy_valid  (out_copy_valid),
    .out_copy_index  (out_copy_index),
    .out_read_done   (out_read_done),
    .out_last        (out_last)
  );

  // Mirror of the sequencer: phase, latched answer, positions, registers
  phase_t              seq_phase;
  logic                ans_seen;
  logic [BYTE_W-1:0]   ans_latch;
  logic [LENGTH_W-1:0] read_pos;
  logic [INDEX_W-1:0]  copy_pos;
  logic                first_read;
  logic [LENGTH_W-1:0] length_reg;
  logic [INDEX_W-1:0]  offset_reg;

  // Beats produced by the latest transfer, and the beats still owed
  beat_t pred_out [2];
  int    pred_n;
  beat_t pending_beats [$];

  int   error_count;
  int   quiet_cycles;
  logic calm;      // no gaps, no stalls for the current phase
  logic answered;  // an answer went in since the last tick

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    if (error_count < MAX_PRINTS)
      $display("ERROR %0t ns: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic compare_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
  endtask

  function automatic beat_t cmd_beat(input logic [BYTE_W-1:0] tx);
    beat_t b;
    b = '0;
    b.tx_byte = tx;
    b.last    = 1'b1;
    return b;
  endfunction

  // Advance the mirror by one accepted transfer; fill pred_out/pred_n
  task automatic advance_sequencer(input logic mode, input logic [BYTE_W-1:0] ans);
    int    limit;
    int    idx;
    logic  done;
    beat_t b;
    pred_n = 0;
    if (mode == MODE_ANSWER) begin
      ans_latch = ans;
      ans_seen  = 1'b1;
      return;
    end
    case (seq_phase)
      PH_RESET: begin
        ans_seen    = 1'b0;
        seq_phase   = PH_WAIT_RESET;
        pred_out[0] = cmd_beat(CMD_RESET_PULSE);
        pred_n      = 1;
      end
      PH_WAIT_RESET: begin
        if (ans_seen && (ans_latch & RESET_ANS_MASK) == RESET_ANS_OK) begin
          seq_phase   = PH_DATA_MODE;
          pred_out[0] = cmd_beat(CMD_DATA_MODE);
          pred_n      = 1;
        end else begin
          seq_phase = PH_RESET;
        end
      end
      PH_DATA_MODE: begin
        ans_seen    = 1'b0;
        seq_phase   = PH_WAIT_SKIP;
        pred_out[0] = cmd_beat(CMD_SKIP_ROM);
        pred_n      = 1;
      end
      PH_WAIT_SKIP: begin
        if (ans_seen && ans_latch == CMD_SKIP_ROM) begin
          seq_phase   = PH_ADDR_LO;
          pred_out[0] = cmd_beat(CMD_READ_MEMORY);
          pred_n      = 1;
        end else begin
          seq_phase = PH_RESET;
        end
      end
      PH_ADDR_LO: begin
        seq_phase   = PH_ADDR_HI;
        pred_out[0] = cmd_beat(ADDR_BYTE);
        pred_n      = 1;
      end
      PH_ADDR_HI: begin
        seq_phase   = PH_START_READ;
        pred_out[0] = cmd_beat(ADDR_BYTE);
        pred_n      = 1;
      end
      PH_START_READ: begin
        seq_phase   = PH_READ;
        read_pos    = '0;
        copy_pos    = '0;
        pred_out[0] = cmd_beat(CMD_READ_SLOT);
        pred_n      = 1;
      end
      default: begin
        // Stop at the register value, clipped to the image size
        limit = (int'(length_reg) > IMAGE_BYTES) ? IMAGE_BYTES : int'(length_reg);
        idx   = int'(read_pos);
        b = '0;
        b.tx_byte     = CMD_READ_SLOT;
        b.store_valid = 1'b1;
        b.store_index = read_pos[INDEX_W-1:0];
        b.store_data  = ans_latch;
        if (first_read && idx >= int'(offset_reg)) begin
          b.copy_valid = 1'b1;
          b.copy_index = copy_pos;
          copy_pos     = copy_pos + INDEX_W'(1);
        end
        read_pos = read_pos + LENGTH_W'(1);
        done     = (idx + 1) >= limit;
        b.last   = !done;
        pred_out[0] = b;
        pred_n      = 1;
        if (done) begin
          seq_phase   = PH_RESET;
          first_read  = 1'b0;
          b = cmd_beat(CMD_COMMAND_END);
          b.read_done = 1'b1;
          pred_out[1] = b;
          pred_n      = 2;
        end
      end
    endcase
  endtask

  task automatic queue_predicted();
    for (int i = 0; i < pred_n; i++)
      pending_beats.push_back(pred_out[i]);
  endtask

  // Mostly back-to-back or short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Offer one transfer, hold it until accepted, then advance the mirror.
  // Called at a rising edge; returns at the edge of acceptance.
  task automatic put_item(input logic mode, input logic [BYTE_W-1:0] ans);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_mode        <= mode;
    in_answer_byte <= ans;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    answered = (mode == MODE_ANSWER);
    advance_sequencer(mode, ans);
  endtask

  // Drop valid, wait for every owed beat, then let silent work finish
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_settings(input logic [CFG_DATA_W-1:0] len,
                               input logic [CFG_DATA_W-1:0] offs);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_DATA_LENGTH;
    cfg_wdata <= len;
    @(posedge clk);
    length_reg = len[LENGTH_W-1:0];
    cfg_index <= CFG_AGEING_OFFSET;
    cfg_wdata <= offs;
    @(posedge clk);
    offset_reg = offs[INDEX_W-1:0];
    cfg_we <= 1'b0;
  endtask

  // Pick the next transfer from where the sequence stands: mostly answers
  // that let the sequence go on, with some bad answers, silence and noise.
  task automatic next_item(output logic mode, output logic [BYTE_W-1:0] ans);
    int r;
    r    = $urandom_range(0, 99);
    mode = MODE_TICK;
    ans  = BYTE_W'($urandom_range(0, 255));
    case (seq_phase)
      PH_WAIT_RESET: begin
        if ((!answered && r < 90) || (answered && r < 5)) begin
          mode = MODE_ANSWER;
          if (r < 80) ans = RESET_ANS_OK | (BYTE_W'($urandom_range(0, 1)) << 5);
        end
      end
      PH_WAIT_SKIP: begin
        if ((!answered && r < 90) || (answered && r < 5)) begin
          mode = MODE_ANSWER;
          if (r < 80) ans = CMD_SKIP_ROM;
        end
      end
      PH_READ: begin
        if (!answered && r < 75) mode = MODE_ANSWER;
      end
      default: begin
        if (r < 6) mode = MODE_ANSWER;
      end
    endcase
  endtask

  initial begin : stimulus
    logic              mode;
    logic [BYTE_W-1:0] ans;
    logic [6:0]        len;
    logic [6:0]        offs;
    int                k;
    rst_n          <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_index      <= CFG_DATA_LENGTH;
    cfg_wdata      <= '0;
    in_valid       <= 1'b0;
    in_mode        <= MODE_TICK;
    in_answer_byte <= '0;
    error_count = 0;
    answered    = 1'b0;
    calm        = 1'b0;
    seq_phase   = PH_RESET;
    ans_seen    = 1'b0;
    ans_latch   = '0;
    read_pos    = '0;
    copy_pos    = '0;
    first_read  = 1'b1;
    length_reg  = DATA_LENGTH_RST;
    offset_reg  = AGEING_OFFSET_RST;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIR_ROWS[i]) begin
      put_item(DIR_ROWS[i].mode, DIR_ROWS[i].answer);
      case (DIR_ROWS[i].chk)
        CHK_MODEL: queue_predicted();
        CHK_TYPED: pending_beats.push_back(cmd_beat(DIR_ROWS[i].typed_tx));
        default: ;
      endcase
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      // Phase 0 keeps the reset settings until the first pass is through
      if (ph > 0) begin
        settle();
        case (ph)
          1: begin len = 7'd0;   offs = 7'd63;  end
          2: begin len = 7'd1;   offs = 7'd0;   end
          3: begin len = 7'd127; offs = 7'd127; end
          4: begin len = 7'd65;  offs = 7'($urandom_range(0, 127)); end
          5: begin len = 7'd64;  offs = 7'($urandom_range(0, 127)); end
          default: begin
            len  = ($urandom_range(0, 4) != 0) ? 7'($urandom_range(1, 8))
                                                 : 7'($urandom_range(0, 127));
            offs = 7'($urandom_range(0, 127));
          end
        endcase
        load_settings(len, offs);
      end
      calm = ($urandom_range(0, 3) == 0);
      k = 0;
      while (k < PHASE_ITEMS || (ph == 0 && first_read)) begin
        next_item(mode, ans);
        put_item(mode, ans);
        queue_predicted();
        k++;
      end
    end

    calm = 1'b0;
    settle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Result sink: ready bursts broken by stalls, none while calm
  initial begin : sink_pacing
    int burst;
    int stall;
    forever begin
      burst = $urandom_range(1, 30);
      out_ready <= 1'b1;
      repeat (burst) @(posedge clk);
      stall = pick_gap();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  // Compare each transfer on the result channel with the oldest owed beat
  always @(posedge clk) begin : result_check
    beat_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_beats.size() == 0) begin
        report_mismatch($sformatf("result with nothing owed, tx_byte 0x%0h",
                                  out_tx_byte));
      end else begin
        want = pending_beats.pop_front();
        compare_field("tx_byte",     out_tx_byte,        want.tx_byte);
        compare_field("store_valid", 8'(out_store_valid), 8'(want.store_valid));
        compare_field("store_index", 8'(out_store_index), 8'(want.store_index));
        compare_field("store_data",  out_store_data,     want.store_data);
        compare_field("copy_valid",  8'(out_copy_valid),  8'(want.copy_valid));
        compare_field("copy_index",  8'(out_copy_index),  8'(want.copy_index));
        compare_field("read_done",   8'(out_read_done),   8'(want.read_done));
        compare_field("last",        8'(out_last),        8'(want.last));
      end
    end
    if ((in_valid && in_ready) || (out_valid && out_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  // Stop a hung run: too long without a transfer on either channel
  initial begin : watchdog
    quiet_cycles = 0;
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
